### rtl/core/gqbp_pkg.sv
// Package: shared types, constants and a helper function of the gray quantize bit packer.
`default_nettype none
package gqbp_pkg;

  localparam logic [7:0] MaxLevelRst = 8'd255;
  localparam logic [3:0] ByteBits    = 4'd8;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoIdxW   = $clog2(FifoDepth);
  localparam int unsigned FifoCntW   = $clog2(FifoDepth + 1);

  // One packed output word.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } gqbp_word_t;

  // Up to two words written into the output queue in one cycle.
  typedef struct packed {
    logic [1:0] cnt;
    gqbp_word_t w0;
    gqbp_word_t w1;
  } gqbp_push_t;

  // Fill level of the output queue.
  typedef struct packed {
    logic [FifoCntW-1:0] count;
  } gqbp_fifo_stat_t;

  // Bit length of the level, with a zero level coded on one bit.
  function automatic logic [3:0] gqbp_code_width(input logic [7:0] lvl);
    logic [3:0] w;
    w = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (lvl[i]) begin
        w = 4'(i + 1);
      end
    end
    return (w == 4'd0) ? 4'd1 : w;
  endfunction

endpackage
`default_nettype wire

### rtl/core/gqbp_pix_if.sv
// Interface: input pixel channel with valid/ready handshake.
`default_nettype none
interface gqbp_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       end_of_image;

  modport source (output valid, output pixel, output end_of_image, input ready);
  modport sink   (input valid, input pixel, input end_of_image, output ready);
endinterface
`default_nettype wire

### rtl/core/gqbp_byte_if.sv
// Interface: packed output byte channel with valid/ready handshake.
`default_nettype none
interface gqbp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       last_byte;

  modport source (output valid, output packed_byte, output last_byte, input ready);
  modport sink   (input valid, input packed_byte, input last_byte, output ready);
endinterface
`default_nettype wire

### rtl/core/gqbp_cfg_if.sv
// Interface: configuration write channel for the max_level register.
`default_nettype none
interface gqbp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] max_level;

  modport source (output valid, output max_level, input ready);
  modport sink   (input valid, input max_level, output ready);
endinterface
`default_nettype wire

### rtl/core/gqbp_out_fifo.sv
// Module: queue that takes up to two words per cycle and gives one if ready_i.
`default_nettype none
module gqbp_out_fifo
  import gqbp_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire gqbp_push_t      push_i,
  output gqbp_fifo_stat_t      stat_o,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output gqbp_word_t           word_o
);

  gqbp_word_t            mem_q [FifoDepth];
  logic [FifoIdxW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FifoIdxW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0]   count_q, count_d;
  logic                  pop;

  assign valid_o      = (count_q != '0);
  assign word_o       = mem_q[rd_ptr_q];
  assign pop          = valid_o && ready_i;
  assign stat_o.count = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q + FifoIdxW'(push_i.cnt);
    rd_ptr_d = rd_ptr_q + FifoIdxW'(pop);
    count_d  = count_q + FifoCntW'(push_i.cnt) - FifoCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.w0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_q + FifoIdxW'(1)] <= push_i.w1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule
`default_nettype wire

### rtl/core/gray_quantize_bit_packer.sv
// Top level: requantizes gray pixels and packs the codes MSB-first into bytes.
// Path: a pixel word is held in the input register, then requantized and packed
//   combinationally and written into the output queue, which feeds byte_o.
// Throughput: one pixel per cycle while the queue holds at most two words; with a ready
//   sink it stalls only once end-of-image pixels that yield two bytes have built a backlog.
// Reset (asynchronous, active low): max_level is 255, the pending byte and both stages empty.
`default_nettype none
module gray_quantize_bit_packer
  import gqbp_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  gqbp_pix_if.sink    pix_i,
  gqbp_cfg_if.sink    cfg_i,
  gqbp_byte_if.source byte_o
);

  // Configuration register. The user must write it only while the block is idle;
  // the block itself does not enforce this. The channel is always ready.
  logic [7:0] max_level_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_level_q <= MaxLevelRst;
    end else if (cfg_i.valid) begin
      max_level_q <= cfg_i.max_level;
    end
  end

  // Input register. It is loaded whenever it is empty or its word moves on,
  // which keeps one pixel per cycle flowing while the queue has room for two.
  logic       a_valid_q;
  logic [7:0] a_pix_q;
  logic       a_eoi_q;
  logic       advance;
  logic       pix_fire;

  gqbp_fifo_stat_t fifo_stat;

  // The packer may emit two bytes for one pixel, so the word in the input
  // register moves on only when the queue has room for two.
  assign advance     = a_valid_q && (fifo_stat.count <= FifoCntW'(FifoDepth - 2));
  assign pix_i.ready = !a_valid_q || advance;
  assign pix_fire    = pix_i.valid && pix_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (pix_i.ready) begin
      a_valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_fire) begin
      a_pix_q <= pix_i.pixel;
      a_eoi_q <= pix_i.end_of_image;
    end
  end

  // Requantization. floor(p / 255) for a 16-bit product p is computed exactly
  // as (p + (p >> 8) + 1) >> 8, which avoids a divider.
  logic [3:0]  width;
  logic [15:0] prod;
  logic [16:0] qsum;
  logic [7:0]  code;
  logic [7:0]  code_mask;

  always_comb begin
    width     = gqbp_code_width(max_level_q);
    prod      = 16'(a_pix_q) * 16'(max_level_q);
    qsum      = 17'(prod) + 17'(prod[15:8]) + 17'd1;
    code_mask = 8'((9'd1 << width) - 9'd1);
    code      = qsum[15:8] & code_mask;
  end

  // Packing state: the partial byte is left-aligned and free_q counts the
  // unused low positions, always between one and eight.
  logic [7:0] pend_q, pend_d;
  logic [3:0] free_q, free_d;

  logic [15:0] code16;
  logic [3:0]  rem;
  logic [7:0]  done_byte;
  logic        done_vld;
  logic [7:0]  pend_nx;
  logic [3:0]  free_nx;
  gqbp_push_t  push;

  always_comb begin
    code16    = {8'h00, code};
    rem       = width - free_q;
    done_byte = 8'h00;
    done_vld  = 1'b0;
    if (width < free_q) begin
      // The code fits in the partial byte with room to spare.
      pend_nx = pend_q | 8'(code16 << (free_q - width));
      free_nx = free_q - width;
    end else begin
      // The code closes the byte; its low rem bits start the next one.
      done_byte = pend_q | 8'(code16 >> rem[2:0]);
      done_vld  = 1'b1;
      pend_nx   = 8'(code16 << (ByteBits - rem));
      free_nx   = ByteBits - rem;
    end

    push.cnt = 2'd0;
    push.w0  = '{data: done_byte, last: 1'b0};
    push.w1  = '{data: pend_nx, last: 1'b1};
    pend_d   = pend_q;
    free_d   = free_q;

    if (advance) begin
      pend_d   = pend_nx;
      free_d   = free_nx;
      push.cnt = {1'b0, done_vld};
      if (a_eoi_q) begin
        // End of image: flush a partial byte, or mark the closed byte as
        // the last one when nothing is left over.
        if (free_nx < ByteBits) begin
          if (done_vld) begin
            push.cnt = 2'd2;
          end else begin
            push.cnt = 2'd1;
            push.w0  = '{data: pend_nx, last: 1'b1};
          end
        end else begin
          push.w0.last = done_vld;
        end
        pend_d = 8'h00;
        free_d = ByteBits;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 8'h00;
      free_q <= ByteBits;
    end else begin
      pend_q <= pend_d;
      free_q <= free_d;
    end
  end

  // Output queue, which also decouples a stalled sink from the input side.
  gqbp_word_t out_word;

  gqbp_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .stat_o  (fifo_stat),
    .valid_o (byte_o.valid),
    .ready_i (byte_o.ready),
    .word_o  (out_word)
  );

  assign byte_o.packed_byte = out_word.data;
  assign byte_o.last_byte   = out_word.last;

  // The free bit count never leaves the range one to eight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_q != 4'd0) && (free_q <= ByteBits))
    else $error("free bit count out of range");

  // The queue never overflows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_stat.count <= FifoCntW'(FifoDepth))
    else $error("output queue overflow");

  // After the final pixel of an image the packer starts on an empty byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && a_eoi_q) |=> ((free_q == ByteBits) && (pend_q == 8'h00)))
    else $error("packer not emptied at end of image");

  // A pixel that closes a byte always queues at least one word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && done_vld) |-> (push.cnt != 2'd0))
    else $error("closed byte dropped");

endmodule
`default_nettype wire

### dv/gqbp_tb_pkg.sv
// Scoreboard class that mirrors the packer state and checks the bytes it emits.
`timescale 1ns / 1ps
package gqbp_tb_pkg;
  import gqbp_pkg::*;

  class byte_packer_mirror;
    logic [7:0] level;
    logic [7:0] partial;
    logic [3:0] room;
    gqbp_word_t bytes_owed[$];
    int unsigned mismatches;

    function new();
      level = MaxLevelRst;
      partial = 8'h00;
      room = ByteBits;
      mismatches = 0;
    endfunction

    function void set_level(input logic [7:0] lvl);
      level = lvl;
    endfunction

    function int unsigned outstanding();
      return bytes_owed.size();
    endfunction

    // Requantizes a pixel, packs its code, queues each byte it completes or pads.
    function void absorb_pixel(input logic [7:0] pix, input logic eoi);
      int unsigned width;
      int unsigned code;
      int unsigned spill;
      bit full;
      gqbp_word_t done_word;
      gqbp_word_t pad_word;
      width = 1;
      for (int i = 0; i < 8; i++) begin
        if (level[i]) width = i + 1;
      end
      code = (32'(pix) * 32'(level)) / 255;
      code = code & ((32'd1 << width) - 1);
      full = 1'b0;
      done_word = '0;
      pad_word = '0;
      if (width < 32'(room)) begin
        partial = partial | 8'(code << (32'(room) - width));
        room = 4'(32'(room) - width);
      end else begin
        // The code closes the byte; any leftover bits start the next one.
        spill = width - 32'(room);
        done_word.data = partial | 8'(code >> spill);
        full = 1'b1;
        partial = 8'(code << (32'(ByteBits) - spill));
        room = 4'(32'(ByteBits) - spill);
      end
      if (full) begin
        done_word.last = eoi && (room == ByteBits);
        bytes_owed.push_back(done_word);
      end
      if (eoi) begin
        if (room != ByteBits) begin
          pad_word.data = partial;
          pad_word.last = 1'b1;
          bytes_owed.push_back(pad_word);
        end
        partial = 8'h00;
        room = ByteBits;
      end
    endfunction

    function void match_byte(input logic [7:0] data, input logic last);
      gqbp_word_t want;
      if (bytes_owed.size() == 0) begin
        mismatches++;
        $display("%0t: byte %h last %b arrived, expected none", $time, data, last);
      end else begin
        want = bytes_owed.pop_front();
        if (data !== want.data) begin
          mismatches++;
          $display("%0t: packed_byte expected %h, actual %h", $time, want.data, data);
        end
        if (last !== want.last) begin
          mismatches++;
          $display("%0t: last_byte expected %b, actual %b", $time, want.last, last);
        end
      end
    endfunction
  endclass

endpackage

### dv/tb_top.sv
// Top-level testbench: feeds pixels and level writes to the packer and checks its byte stream.
`timescale 1ns / 1ps
module tb_top;
  import gqbp_pkg::*;
  import gqbp_tb_pkg::*;

  // Rough count of pixels after which the random part stops.
  localparam int unsigned PixelTarget = 1000;
  // A pixel that completes no byte may still sit in the input register once
  // every owed byte has arrived, so level writes wait this many extra cycles.
  localparam int unsigned SettleCycles = 4;
  // Cycles without any accepted word before the run is declared hung.
  localparam int unsigned StallLimit = 1000;

  logic clk_i;
  logic rst_ni;

  gqbp_pix_if  pix_if ();
  gqbp_cfg_if  cfg_if ();
  gqbp_byte_if byte_if ();

  byte_packer_mirror mirror = new();

  int unsigned pixels_sent = 0;
  int unsigned pix_calm = 0;
  int unsigned byte_calm = 0;
  int unsigned quiet_cycles = 0;

  gray_quantize_bit_packer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .cfg_i  (cfg_if),
    .byte_o (byte_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Draws the idle cycles before the next word on one side. Now and then a
  // run of back-to-back words is started so that full-rate stretches occur.
  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // Offers one pixel word and returns at the edge where it is taken. When no
  // gap is drawn, valid simply stays high into the next word.
  task automatic send_pixel(input logic [7:0] pix, input logic eoi);
    int unsigned gap;
    gap = draw_wait(pix_calm);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= pix;
    pix_if.end_of_image <= eoi;
    do @(posedge clk_i); while (!pix_if.ready);
    mirror.absorb_pixel(pix, eoi);
    pixels_sent++;
  endtask

  // Stops the pixel stream and waits until the packer has nothing in flight.
  task automatic drain();
    pix_if.valid <= 1'b0;
    while (mirror.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes max_level; only called after drain(), so the packer is idle.
  task automatic write_level(input logic [7:0] lvl);
    cfg_if.valid <= 1'b1;
    cfg_if.max_level <= lvl;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    mirror.set_level(lvl);
  endtask

  // Byte sink: stalls a random number of cycles before each word, then holds
  // ready until a word is taken and checks it against the oldest owed byte.
  initial begin
    int unsigned stall;
    byte_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_wait(byte_calm);
      if (stall > 0) begin
        byte_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      byte_if.ready <= 1'b1;
      do @(posedge clk_i); while (!byte_if.valid);
      mirror.match_byte(byte_if.packed_byte, byte_if.last_byte);
    end
  end

  // Watchdog: any accepted word on any channel counts as progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pix_if.valid && pix_if.ready) || (byte_if.valid && byte_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [7:0] lvl;
    logic [7:0] pix;
    logic       eoi;
    int unsigned images;
    int unsigned len;
    int unsigned k;
    bit cut;

    rst_ni <= 1'b0;
    pix_if.valid <= 1'b0;
    pix_if.pixel <= 8'h00;
    pix_if.end_of_image <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.max_level <= MaxLevelRst;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset level of 255 gives 8-bit codes: each pixel fills a byte exactly,
    // so the image ends on a whole byte and no padding byte follows.
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd128, 1'b1);

    // Level 1 packs one bit per pixel. Eight pixels fill one byte exactly at
    // the end of the image; then a short image is flushed with padding.
    drain();
    write_level(8'd1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd254, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b1);

    // Three-bit codes: the third code spans the byte boundary, so the last
    // pixel emits a full byte and then the padded partial byte.
    drain();
    write_level(8'd7);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd255, 1'b1);

    // Level change in the middle of an image: six bits stay pending, then an
    // 8-bit code splits across the pending byte and the flushed one.
    drain();
    write_level(8'd5);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd255, 1'b0);
    drain();
    write_level(8'd255);
    send_pixel(8'd255, 1'b1);

    drain();
    write_level(8'd128);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd1, 1'b1);

    // Random phases: a fresh level, then a few images of random content.
    // Sometimes the last image is left open so the next level starts
    // mid-image, and a few stray end markers cut images short.
    while (pixels_sent < PixelTarget) begin
      drain();
      case ($urandom_range(0, 5))
        0: lvl = 8'd1;
        1: lvl = 8'd255;
        2: begin
          k = $urandom_range(1, 7);
          lvl = 8'((32'd1 << k) - 1 + $urandom_range(0, 1));
        end
        default: lvl = 8'($urandom_range(1, 255));
      endcase
      write_level(lvl);
      images = $urandom_range(1, 3);
      cut = ($urandom_range(0, 4) == 0);
      for (int img = 0; img < images; img++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 12);
        for (int n = 0; n < len; n++) begin
          case ($urandom_range(0, 7))
            0: pix = 8'd0;
            1: pix = 8'd255;
            default: pix = 8'($urandom_range(0, 255));
          endcase
          if (n == len - 1) begin
            eoi = !(cut && (img == images - 1));
          end else begin
            eoi = ($urandom_range(0, 29) == 0);
          end
          send_pixel(pix, eoi);
        end
      end
    end

    drain();
    if (mirror.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/gqbp_pkg.sv
rtl/core/gqbp_pix_if.sv
rtl/core/gqbp_byte_if.sv
rtl/core/gqbp_cfg_if.sv
rtl/core/gqbp_out_fifo.sv
rtl/core/gray_quantize_bit_packer.sv
dv/gqbp_tb_pkg.sv
dv/tb_top.sv
